// ===== rtl/core/boundary_tag_first_fit_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Boundary-tag allocator assertion macros
// Shared concurrent assertion forms for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BTFF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication, checked out of reset.
`define BTFF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

`endif

// ===== rtl/core/btff_pkg.sv =====
// ----------------------------------------------------------------------------
// Boundary-tag allocator package
// Types, codes and widths shared by the allocator controller and datapath.
// ----------------------------------------------------------------------------
package btff_pkg;

    localparam int HEAP_WORDS_DEF = 16384;
    localparam int LEN_W          = 15;
    localparam int POS_W          = 16;
    localparam int WORD_W         = 32;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_SIZE  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] request_bytes;
        logic [14:0] block_offset;
    } t_req;

    typedef struct packed {
        logic        status;
        logic [14:0] data_offset;
        logic [16:0] block_bytes;
    } t_rsp;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_INIT,
        OP_LOAD,
        OP_RD_CUR,
        OP_SCAN,
        OP_SPLIT,
        OP_FIX,
        OP_F_HDR,
        OP_F_PREV,
        OP_RD_NEXT,
        OP_F_NEXT,
        OP_RD_FOLLOW,
        OP_RD_START,
        OP_F_START,
        OP_RES_SIZE,
        OP_RES_OK,
        OP_RES_FAIL,
        OP_RES_ZERO
    } t_dp_op;

    typedef struct packed {
        logic [1:0] cmd;
        logic       off_ok;
        logic       fit;
        logic       stop;
        logic       has_prev;
        logic       next_in;
    } t_dp_stat;

endpackage

// ===== rtl/core/btff_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module btff_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/btff_dp.sv =====
// ----------------------------------------------------------------------------
// Boundary-tag allocator datapath
// Header store, scan and merge arithmetic, and the result register.
// ----------------------------------------------------------------------------
module btff_dp #(
    parameter int HEAP_WORDS = btff_pkg::HEAP_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  btff_pkg::t_req     i_req,
    input  btff_pkg::t_dp_op   i_op,
    output btff_pkg::t_dp_stat o_stat,
    output btff_pkg::t_rsp     o_rsp,
    output logic               o_done
);
    import btff_pkg::*;

    localparam int AW = $clog2(HEAP_WORDS);
    localparam logic [POS_W-1:0]  HEAP_END   = POS_W'(HEAP_WORDS);
    localparam logic [WORD_W-1:0] WORD0_INIT = {{(WORD_W-LEN_W){1'b0}}, HEAP_END[LEN_W-1:0]};

    logic [1:0]       r_cmd,    n_cmd;
    logic             r_off_ok, n_off_ok;
    logic [LEN_W-1:0] r_req,    n_req;
    logic [LEN_W-1:0] r_cur,    n_cur;
    logic [LEN_W-1:0] r_len,    n_len;
    logic [POS_W-1:0] r_next,   n_next;
    logic [LEN_W-1:0] r_start,  n_start;
    logic [LEN_W-1:0] r_prev,   n_prev;
    logic [POS_W-1:0] r_follow, n_follow;
    logic [15:0]      r_prev16, n_prev16;
    t_rsp             r_rsp,    n_rsp;
    logic             r_done,   n_done;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] rdata;

    logic [LEN_W-1:0] hdr_len;
    logic [LEN_W-1:0] hdr_plen;
    logic             hdr_alloc;
    logic [16:0]      req_sum;
    logic [POS_W-1:0] scan_sum;
    logic [POS_W-1:0] next_sum;
    logic [LEN_W-1:0] spare;
    logic [LEN_W-1:0] prev_pos;
    logic [LEN_W-1:0] merge_len;
    logic [POS_W-1:0] merge_follow;
    logic             fit;
    logic             has_prev;
    logic             next_in;
    logic             follow_in;

    btff_ram #(
        .WIDTH (WORD_W),
        .DEPTH (HEAP_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    assign hdr_len      = rdata[LEN_W-1:0];
    assign hdr_plen     = rdata[30:16];
    assign hdr_alloc    = rdata[15];
    assign req_sum      = {1'b0, i_req.request_bytes} + 17'd7;
    assign scan_sum     = {1'b0, r_cur} + {1'b0, hdr_len};
    assign next_sum     = {1'b0, r_cur} + {1'b0, r_req};
    assign spare        = hdr_len - r_req;
    assign prev_pos     = r_cur - hdr_plen;
    assign merge_len    = r_len + hdr_len;
    assign merge_follow = r_next + {1'b0, hdr_len};
    assign fit          = !hdr_alloc && (r_req <= hdr_len);
    assign has_prev     = hdr_plen <= r_cur;
    assign next_in      = r_next < HEAP_END;
    assign follow_in    = r_follow < HEAP_END;

    always_comb begin
        n_cmd     = r_cmd;
        n_off_ok  = r_off_ok;
        n_req     = r_req;
        n_cur     = r_cur;
        n_len     = r_len;
        n_next    = r_next;
        n_start   = r_start;
        n_prev    = r_prev;
        n_follow  = r_follow;
        n_prev16  = r_prev16;
        n_rsp     = r_rsp;
        n_done    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_cur[AW-1:0];
        ram_wdata = '0;
        ram_raddr = r_cur[AW-1:0];
        unique case (i_op)
            OP_NOP: begin
            end
            OP_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = WORD0_INIT;
            end
            OP_LOAD: begin
                n_cmd    = i_req.command;
                n_req    = req_sum[16:2];
                n_cur    = (i_req.command == CMD_ALLOC) ? '0 : i_req.block_offset - 15'd1;
                n_off_ok = (i_req.block_offset != '0) && ({1'b0, i_req.block_offset} <= HEAP_END);
            end
            OP_RD_CUR: begin
                ram_raddr = r_cur[AW-1:0];
            end
            OP_SCAN: begin
                if (fit) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cur[AW-1:0];
                    ram_wdata = {rdata[31:16], 1'b1, r_req};
                    n_len     = hdr_len;
                    n_follow  = scan_sum;
                    n_next    = next_sum;
                    n_prev16  = (hdr_len != r_req) ? {1'b0, spare} : {1'b1, r_req};
                end else begin
                    n_cur = scan_sum[LEN_W-1:0];
                end
            end
            OP_SPLIT: begin
                ram_raddr = r_follow[AW-1:0];
                if ((r_len != r_req) && next_in) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_next[AW-1:0];
                    ram_wdata = {1'b1, r_req, r_prev16};
                end
            end
            OP_FIX: begin
                if (follow_in) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_follow[AW-1:0];
                    ram_wdata = {r_prev16, rdata[15:0]};
                end
            end
            OP_F_HDR: begin
                n_len     = hdr_len;
                n_next    = scan_sum;
                n_start   = r_cur;
                n_prev    = prev_pos;
                ram_raddr = prev_pos[AW-1:0];
            end
            OP_F_PREV: begin
                ram_raddr = r_next[AW-1:0];
                if (!hdr_alloc) begin
                    n_len   = merge_len;
                    n_start = r_prev;
                end
            end
            OP_RD_NEXT: begin
                ram_raddr = r_next[AW-1:0];
            end
            OP_F_NEXT: begin
                if (!hdr_alloc) begin
                    n_len    = merge_len;
                    n_follow = merge_follow;
                    n_prev16 = {1'b0, merge_len};
                end else begin
                    n_follow = r_next;
                    n_prev16 = {1'b0, r_len};
                end
            end
            OP_RD_FOLLOW: begin
                ram_raddr = r_follow[AW-1:0];
            end
            OP_RD_START: begin
                ram_raddr = r_start[AW-1:0];
            end
            OP_F_START: begin
                ram_we    = 1'b1;
                ram_waddr = r_start[AW-1:0];
                ram_wdata = {rdata[31:16], 1'b0, r_len};
            end
            OP_RES_SIZE: begin
                n_rsp.status      = 1'b0;
                n_rsp.data_offset = '0;
                n_rsp.block_bytes = {hdr_len, 2'b00};
                n_done            = 1'b1;
            end
            OP_RES_OK: begin
                n_rsp.status      = 1'b0;
                n_rsp.data_offset = r_cur + 15'd1;
                n_rsp.block_bytes = '0;
                n_done            = 1'b1;
            end
            OP_RES_FAIL: begin
                n_rsp.status      = 1'b1;
                n_rsp.data_offset = '0;
                n_rsp.block_bytes = '0;
                n_done            = 1'b1;
            end
            OP_RES_ZERO: begin
                n_rsp.status      = 1'b0;
                n_rsp.data_offset = '0;
                n_rsp.block_bytes = '0;
                n_done            = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_off_ok <= n_off_ok;
        r_req    <= n_req;
        r_cur    <= n_cur;
        r_len    <= n_len;
        r_next   <= n_next;
        r_start  <= n_start;
        r_prev   <= n_prev;
        r_follow <= n_follow;
        r_prev16 <= n_prev16;
        r_rsp    <= n_rsp;
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.off_ok   = r_off_ok;
    assign o_stat.fit      = fit;
    assign o_stat.stop     = (hdr_len == '0) || (scan_sum >= HEAP_END);
    assign o_stat.has_prev = has_prev;
    assign o_stat.next_in  = next_in;
    assign o_rsp           = r_rsp;
    assign o_done          = r_done;

endmodule

// ===== rtl/core/btff_ctrl.sv =====
// ----------------------------------------------------------------------------
// Boundary-tag allocator controller
// Sequences header reads and writes for allocate, free and size query.
// ----------------------------------------------------------------------------
module btff_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  btff_pkg::t_dp_stat i_stat,
    output btff_pkg::t_dp_op   o_op,
    output logic               o_busy
);
    import btff_pkg::*;

    typedef enum logic [18:0] {
        ST_INIT    = 19'h00001,
        ST_IDLE    = 19'h00002,
        ST_DECODE  = 19'h00004,
        ST_A_RD    = 19'h00008,
        ST_A_CHK   = 19'h00010,
        ST_A_SPLIT = 19'h00020,
        ST_A_FIX   = 19'h00040,
        ST_F_HDR   = 19'h00080,
        ST_F_PREV  = 19'h00100,
        ST_F_NRD   = 19'h00200,
        ST_F_NEXT  = 19'h00400,
        ST_F_FRD   = 19'h00800,
        ST_F_FIX   = 19'h01000,
        ST_F_SRD   = 19'h02000,
        ST_F_SWR   = 19'h04000,
        ST_Q_CHK   = 19'h08000,
        ST_R_OK    = 19'h10000,
        ST_R_FAIL  = 19'h20000,
        ST_R_ZERO  = 19'h40000
    } t_state;

    t_state r_state, n_state;
    t_dp_op op;

    always_comb begin
        n_state = r_state;
        op      = OP_NOP;
        unique case (r_state)
            ST_INIT: begin
                op      = OP_INIT;
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_start) begin
                    op      = OP_LOAD;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                op = OP_RD_CUR;
                unique case (i_stat.cmd)
                    CMD_ALLOC: n_state = ST_A_CHK;
                    CMD_FREE:  n_state = i_stat.off_ok ? ST_F_HDR : ST_R_ZERO;
                    CMD_SIZE:  n_state = i_stat.off_ok ? ST_Q_CHK : ST_R_ZERO;
                    default:   n_state = ST_R_ZERO;
                endcase
            end
            ST_A_RD: begin
                op      = OP_RD_CUR;
                n_state = ST_A_CHK;
            end
            ST_A_CHK: begin
                op = OP_SCAN;
                if (i_stat.fit) begin
                    n_state = ST_A_SPLIT;
                end else if (i_stat.stop) begin
                    n_state = ST_R_FAIL;
                end else begin
                    n_state = ST_A_RD;
                end
            end
            ST_A_SPLIT: begin
                op      = OP_SPLIT;
                n_state = ST_A_FIX;
            end
            ST_A_FIX: begin
                op      = OP_FIX;
                n_state = ST_R_OK;
            end
            ST_F_HDR: begin
                op      = OP_F_HDR;
                n_state = i_stat.has_prev ? ST_F_PREV : ST_F_NRD;
            end
            ST_F_PREV: begin
                op      = OP_F_PREV;
                n_state = i_stat.next_in ? ST_F_NEXT : ST_F_SRD;
            end
            ST_F_NRD: begin
                op      = OP_RD_NEXT;
                n_state = i_stat.next_in ? ST_F_NEXT : ST_F_SRD;
            end
            ST_F_NEXT: begin
                op      = OP_F_NEXT;
                n_state = ST_F_FRD;
            end
            ST_F_FRD: begin
                op      = OP_RD_FOLLOW;
                n_state = ST_F_FIX;
            end
            ST_F_FIX: begin
                op      = OP_FIX;
                n_state = ST_F_SRD;
            end
            ST_F_SRD: begin
                op      = OP_RD_START;
                n_state = ST_F_SWR;
            end
            ST_F_SWR: begin
                op      = OP_F_START;
                n_state = ST_R_ZERO;
            end
            ST_Q_CHK: begin
                op      = OP_RES_SIZE;
                n_state = ST_IDLE;
            end
            ST_R_OK: begin
                op      = OP_RES_OK;
                n_state = ST_IDLE;
            end
            ST_R_FAIL: begin
                op      = OP_RES_FAIL;
                n_state = ST_IDLE;
            end
            ST_R_ZERO: begin
                op      = OP_RES_ZERO;
                n_state = ST_IDLE;
            end
            default: begin
                op      = OP_NOP;
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_op   = op;
    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/core/boundary_tag_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// Boundary-tag first-fit allocator
// Commands are taken when start is high and busy is low, one at a time, and
// each gives exactly one result beat on o_rsp, marked by o_done for a single
// cycle that the receiver cannot hold off. All timing comes from the single
// read and single write port of the header store. A size query reads one
// header. A free also reads the headers after the block when a following
// block lies inside the heap. An allocate visits headers in order from word
// 0 until one fits or the scan stops. A new command may be given in the
// cycle of the result beat. After reset the block is busy in its init state
// while word 0 of the store is set.
// ----------------------------------------------------------------------------
`include "boundary_tag_first_fit_allocator_macros.svh"

module boundary_tag_first_fit_allocator #(
    parameter int HEAP_WORDS = btff_pkg::HEAP_WORDS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  btff_pkg::t_req i_req,
    output btff_pkg::t_rsp o_rsp,
    output logic           o_done
);
    import btff_pkg::*;

    t_dp_op   dp_op;
    t_dp_stat dp_stat;

    btff_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_op    (dp_op),
        .o_busy  (busy)
    );

    btff_dp #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_op    (dp_op),
        .o_stat  (dp_stat),
        .o_rsp   (o_rsp),
        .o_done  (o_done)
    );

    `BTFF_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `BTFF_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `BTFF_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_done)
    `BTFF_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_done && o_rsp.status, o_rsp.data_offset == '0 && o_rsp.block_bytes == '0)

endmodule
